>>> rtl/programmable_fsm_transition_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the programmable FSM transition table unit.
// Each macro expects clk and rst in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef PROGRAMMABLE_FSM_TRANSITION_TABLE_UNIT_DEFINES_SVH
`define PROGRAMMABLE_FSM_TRANSITION_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PFSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define PFSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pfsm_pkg.sv
// ----------------------------------------------------------------------------
// pfsm_pkg
// Shared types and codes of the programmable FSM transition table unit.
// ----------------------------------------------------------------------------
package pfsm_pkg;

  localparam int StateW = 8;
  localparam int ActW   = 8;
  localparam int HndW   = 8;

  typedef logic [StateW-1:0] state_id_t;
  typedef logic [ActW-1:0]   action_t;
  typedef logic [HndW-1:0]   handler_t;

  // Command codes
  typedef enum logic [1:0] {
    CMD_ADD_STATE = 2'd0,
    CMD_ADD_LINK  = 2'd1,
    CMD_CHECK     = 2'd2,
    CMD_SEND      = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_DUP        = 3'd1,
    ST_INVALID    = 3'd2,
    ST_NOTFOUND   = 3'd3,
    ST_OUTOFSTATE = 3'd4,
    ST_FULL       = 3'd5
  } status_t;

  // One stored link
  typedef struct packed {
    state_id_t src;
    state_id_t dst;
    action_t   act;
    handler_t  hnd;
  } link_t;

  // Key presented to the shared compare unit
  typedef struct packed {
    logic      by_action;
    state_id_t src;
    logic [7:0] key;
  } match_req_t;

  // Result word
  typedef struct packed {
    status_t   status;
    state_id_t next_state;
    logic      fire;
    handler_t  fid;
  } result_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_POST
  } fsm_t;

endpackage

>>> rtl/pfsm_cmd_if.sv
// ----------------------------------------------------------------------------
// pfsm_cmd_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface pfsm_cmd_if;
  import pfsm_pkg::*;

  logic      valid;
  logic      ready;
  cmd_t      command;
  state_id_t state_a;
  state_id_t state_b;
  action_t   action_code;
  handler_t  handler_id;

  modport source (
    output valid, command, state_a, state_b, action_code, handler_id,
    input  ready
  );

  modport sink (
    input  valid, command, state_a, state_b, action_code, handler_id,
    output ready
  );
endinterface

>>> rtl/pfsm_rsp_if.sv
// ----------------------------------------------------------------------------
// pfsm_rsp_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface pfsm_rsp_if;
  import pfsm_pkg::*;

  logic      valid;
  logic      ready;
  status_t   status;
  state_id_t next_state;
  logic      fire_handler;
  handler_t  fired_handler_id;

  modport source (
    output valid, status, next_state, fire_handler, fired_handler_id,
    input  ready
  );

  modport sink (
    input  valid, status, next_state, fire_handler, fired_handler_id,
    output ready
  );
endinterface

>>> rtl/pfsm_link_ram.sv
// ----------------------------------------------------------------------------
// pfsm_link_ram
// Link table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pfsm_link_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  pfsm_pkg::link_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output pfsm_pkg::link_t rdata
);
  import pfsm_pkg::*;

  link_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> rtl/pfsm_match_unit.sv
// ----------------------------------------------------------------------------
// pfsm_match_unit
// Shared compare unit: tests one link entry against the lookup key.
// ----------------------------------------------------------------------------
module pfsm_match_unit (
  input  pfsm_pkg::link_t      entry,
  input  pfsm_pkg::match_req_t req,
  output logic                 hit
);
  import pfsm_pkg::*;

  logic [7:0] field;

  // Key field is the action for send, the target for check
  assign field = req.by_action ? entry.act : entry.dst;
  assign hit   = (entry.src == req.src) && (field == req.key);
endmodule

>>> rtl/programmable_fsm_transition_table_unit.sv
// ----------------------------------------------------------------------------
// programmable_fsm_transition_table_unit
// Programmable transition table for a table-driven state machine.
//
// Channels: cmd carries one command beat (add state, add link, check
// transition, send action); rsp returns exactly one result beat for each.
// Both use valid/ready; a beat moves when both are high.
// Sequence: add state, add link and lookups from an undeclared state go
// from the command registers to the result register. Other lookups scan the
// link table newest first, one RAM read and one compare per cycle through
// a single compare unit, stopping at the first hit or after the oldest link.
// One command is in flight at a time; cmd.ready is high only while idle,
// so a command beat is taken only after the last result leaves the sequencer.
// Results sit in an output register, so a new command is taken while the
// last result waits; if rsp stalls, the next result holds in the
// sequencer until the output register frees up.
// Reset clears all declared states and the link count at once; the link
// RAM is not cleared, since only entries below the link count are read.
// ----------------------------------------------------------------------------
`include "programmable_fsm_transition_table_unit_defines.svh"

module programmable_fsm_transition_table_unit #(
  parameter int MAX_LINKS = 16
) (
  input logic       clk,
  input logic       rst,
  pfsm_cmd_if.sink  cmd,
  pfsm_rsp_if.source rsp
);
  import pfsm_pkg::*;

  localparam int CNT_W = $clog2(MAX_LINKS + 1);
  localparam int IDX_W = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;

  // Control state
  fsm_t             state;
  fsm_t             state_next;
  logic [255:0]     present;
  logic [CNT_W-1:0] link_count;
  logic             pend;
  logic             out_valid;

  // Payload registers
  cmd_t             op;
  state_id_t        sa;
  state_id_t        sb;
  action_t          act;
  handler_t         hnd;
  logic [CNT_W-1:0] idx;
  result_t          res;
  result_t          out_res;

  // Combinational controls
  logic             in_ready;
  logic             ram_we;
  logic             ram_re;
  logic             set_present;
  logic             scan_start;
  logic             res_load;
  logic             out_load;
  result_t          res_next;
  logic             is_lookup;
  logic             match;
  logic             hit;
  logic [CNT_W-1:0] idx_dec;
  status_t          fail_status;
  link_t            rd_entry;
  link_t            wr_entry;
  match_req_t       req;

  assign is_lookup   = (op == CMD_CHECK) || (op == CMD_SEND);
  assign fail_status = (op == CMD_SEND) ? ST_OUTOFSTATE : ST_NOTFOUND;
  assign idx_dec     = idx - CNT_W'(1);
  assign wr_entry    = '{src: sa, dst: sb, act: act, hnd: hnd};
  assign req         = '{by_action: (op == CMD_SEND), src: sa,
                         key: ((op == CMD_SEND) ? act : sb)};
  assign hit         = pend && match;
  assign out_load    = (state == S_POST) && (!out_valid || rsp.ready);

  // Link storage and shared compare unit
  pfsm_link_ram #(
    .DEPTH (MAX_LINKS),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (link_count[IDX_W-1:0]),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (idx_dec[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  pfsm_match_unit u_match (
    .entry (rd_entry),
    .req   (req),
    .hit   (match)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (is_lookup && present[sa]) state_next = S_SCAN;
        else                          state_next = S_POST;
      end
      S_SCAN: begin
        if (hit || (idx == '0)) state_next = S_POST;
      end
      S_POST: begin
        if (!out_valid || rsp.ready) state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready    = (state == S_IDLE);
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    set_present = 1'b0;
    scan_start  = 1'b0;
    res_load    = 1'b0;
    res_next    = '{status: ST_OK, next_state: '0, fire: 1'b0, fid: '0};
    unique case (state)
      S_EXEC: begin
        unique case (op)
          CMD_ADD_STATE: begin
            res_load = 1'b1;
            if (present[sa]) res_next.status = ST_DUP;
            else             set_present     = 1'b1;
          end
          CMD_ADD_LINK: begin
            res_load = 1'b1;
            if (!present[sb] || !present[sa]) begin
              res_next.status = ST_INVALID;
            end else if (link_count == CNT_W'(MAX_LINKS)) begin
              res_next.status = ST_FULL;
            end else begin
              ram_we = 1'b1;
            end
          end
          CMD_CHECK, CMD_SEND: begin
            if (present[sa]) begin
              scan_start = 1'b1;
            end else begin
              res_load        = 1'b1;
              res_next.status = fail_status;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (hit) begin
          res_load            = 1'b1;
          res_next.next_state = rd_entry.dst;
          res_next.fid        = rd_entry.hnd;
          res_next.fire       = (rd_entry.hnd != '0);
        end else if (idx == '0) begin
          res_load        = 1'b1;
          res_next.status = fail_status;
        end else begin
          ram_re = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      present    <= '0;
      link_count <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= ram_re;
      if (set_present) present[sa] <= 1'b1;
      if (ram_we)      link_count  <= link_count + CNT_W'(1);
      if (out_load)       out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.valid && in_ready) begin
      op  <= cmd.command;
      sa  <= cmd.state_a;
      sb  <= cmd.state_b;
      act <= cmd.action_code;
      hnd <= cmd.handler_id;
    end
    if (scan_start)  idx <= link_count;
    else if (ram_re) idx <= idx_dec;
    if (res_load) res     <= res_next;
    if (out_load) out_res <= res;
  end

  // Port drive
  assign cmd.ready            = in_ready;
  assign rsp.valid            = out_valid;
  assign rsp.status           = out_res.status;
  assign rsp.next_state       = out_res.next_state;
  assign rsp.fire_handler     = out_res.fire;
  assign rsp.fired_handler_id = out_res.fid;

  // Checks
  `PFSM_ASSERT_NOW(a_count_max, 1'b1, link_count <= CNT_W'(MAX_LINKS), "link count overflow")
  `PFSM_ASSERT_NEXT(a_count_inc, ram_we, link_count == $past(link_count) + CNT_W'(1), "count step")
  `PFSM_ASSERT_NOW(a_read_range, ram_re, idx != '0, "scan read below newest-first range")
  `PFSM_ASSERT_NOW(a_rsp_rise, $rose(rsp.valid), $past(state) == S_POST, "result without completion")
endmodule
